### rtl/iad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iad_pkg
// Shared widths, register indexes and reset values of the interleaved
// average decimator.
// ----------------------------------------------------------------------------
package iad_pkg;

   localparam int SAMPLE_W      = 32;  // raw sample and average ports
   localparam int SUM_W         = 40;  // signed block sum
   localparam int CHAN_IDX_W    = 3;   // channel index port
   localparam int CHANS_W       = 5;   // holds a channel count of up to 16
   localparam int BYTES_W       = 3;   // sample_bytes register
   localparam int COUNT_W       = 4;   // channel_count register
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 4;

   localparam int DEF_BLOCK_LENGTH = 4;
   localparam int DEF_MAX_CHANNELS = 8;

   localparam logic [BYTES_W-1:0] RST_SAMPLE_BYTES  = 3'd2;
   localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 4'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_BYTES  = 2'd0,
      CSR_CHANNEL_COUNT = 2'd1
   } csr_index_type;

   // Sample width as bytes minus one, after folding the undefined codes.
   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_24 = 2'd2,
      WIDTH_32 = 2'd3
   } width_type;

endpackage

### rtl/interleaved_average_decimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interleaved_average_decimator
// Boxcar averaging decimator for an interleaved multichannel sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   Requests on req_ carry one raw sample each, channels interleaved in the
//   order 0, 1, ..., channel_count-1. Every sample is sign-extended from the
//   sample_bytes width and added to its channel's block sum. The sample on
//   the last frame of a block produces one response on rsp_: the block sum
//   divided by BLOCK_LENGTH, truncated toward zero, packed to the sample
//   width, together with its channel index. Other samples give no response.
//   Throughput is one request per cycle while the response path is not
//   stalled. A response passes, in order, through an accumulate stage
//   loaded when its request is accepted, a stage of two registered partial
//   products of the reciprocal multiply, and the output register. Each
//   of these stages holds its content while the next one is full and
//   stalled, so a stalled receiver blocks req_ready only once the first
//   stage holds a response waiting to move on.
//   A csr_ write to index 0 or 1 sets a register and restarts the channel and
//   frame counters; the user must make writes only while the block is idle, unenforced.
//   Reset restores sample_bytes = 2 and channel_count = 2, clears the counters
//   and empties the pipeline. The block sums need no clearing because the
//   first frame of each block loads them.
// ----------------------------------------------------------------------------
module interleaved_average_decimator
   import iad_pkg::*;
#(
   parameter int BLOCK_LENGTH = DEF_BLOCK_LENGTH,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_sample_raw,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SAMPLE_W-1:0]   rsp_average_raw,
   output logic [CHAN_IDX_W-1:0] rsp_channel_index,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int FRM_W  = $clog2(BLOCK_LENGTH);
   localparam int HALF_W = SUM_W / 2;
   localparam int DIV_K  = SUM_W + FRM_W;
   localparam int MAG_W  = SUM_W + 1;
   localparam int PP_W   = HALF_W + MAG_W;
   localparam int PROD_W = SUM_W + MAG_W;
   localparam logic [63:0] MAGIC_FULL =
      ((64'd1 << DIV_K) + 64'(BLOCK_LENGTH) - 64'd1) / 64'(BLOCK_LENGTH);
   localparam logic [MAG_W-1:0] MAGIC = MAGIC_FULL[MAG_W-1:0];
   localparam logic [CHANS_W-1:0] MAX_CHANS = CHANS_W'(MAX_CHANNELS);
   localparam logic [FRM_W:0] LAST_FRAME = (FRM_W+1)'(BLOCK_LENGTH - 1);

   // Configuration and counters.
   logic [BYTES_W-1:0]    sample_bytes_ff,  sample_bytes_in;
   logic [COUNT_W-1:0]    channel_count_ff, channel_count_in;
   logic [POS_W-1:0]      position_ff,      position_in;
   logic [FRM_W-1:0]      frame_ff,         frame_in;
   logic signed [SUM_W-1:0] sums_ff [MAX_CHANNELS];

   // Pipeline.
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_neg_ff;
   logic [SUM_W-1:0]      s1_mag_ff;
   logic [CHAN_IDX_W-1:0] s1_chan_ff;
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_neg_ff;
   logic [PP_W-1:0]       s2_hi_ff, s2_lo_ff;
   logic [CHAN_IDX_W-1:0] s2_chan_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_average_ff;
   logic [CHAN_IDX_W-1:0] rsp_chan_ff;

   width_type               width;
   logic [CHANS_W-1:0]      chans;
   logic [CHANS_W-1:0]      pos_ext, pos_next;
   logic [POS_W-1:0]        pos_cur;
   logic [FRM_W:0]          frame_cur, frame_next;
   logic signed [SUM_W-1:0] sample_ext, sum_new;
   logic [SUM_W-1:0]        sum_mag;
   logic                    accept, last_frame;
   logic                    s3_move, s2_move, s1_move;
   logic [PROD_W-1:0]       product;
   logic [SUM_W-1:0]        quotient, average;
   logic [SAMPLE_W-1:0]     width_mask;

   assign csr_ready = 1'b1;

   always_comb begin
      if (sample_bytes_ff == 3'd0) begin
         width = WIDTH_8;
      end else if (sample_bytes_ff > 3'd4) begin
         width = WIDTH_32;
      end else begin
         width = width_type'(2'(sample_bytes_ff - 3'd1));
      end
      if (channel_count_ff == '0) begin
         chans = CHANS_W'(1);
      end else if (CHANS_W'(channel_count_ff) > MAX_CHANS) begin
         chans = MAX_CHANS;
      end else begin
         chans = CHANS_W'(channel_count_ff);
      end
   end

   always_comb begin
      unique case (width)
         WIDTH_8: begin
            sample_ext = SUM_W'(signed'(req_sample_raw[7:0]));
            width_mask = 32'h0000_00FF;
         end
         WIDTH_16: begin
            sample_ext = SUM_W'(signed'(req_sample_raw[15:0]));
            width_mask = 32'h0000_FFFF;
         end
         WIDTH_24: begin
            sample_ext = SUM_W'(signed'(req_sample_raw[23:0]));
            width_mask = 32'h00FF_FFFF;
         end
         WIDTH_32: begin
            sample_ext = SUM_W'(signed'(req_sample_raw[31:0]));
            width_mask = 32'hFFFF_FFFF;
         end
         default: begin
            sample_ext = '0;
            width_mask = '0;
         end
      endcase
   end

   // Handshake: each stage loads when empty or when its content moves on.
   assign s3_move   = !rsp_valid_ff || rsp_ready;
   assign s2_move   = !s2_valid_ff || s3_move;
   assign s1_move   = !s1_valid_ff || s2_move;
   assign req_ready = s1_move;
   assign accept    = req_valid && req_ready;

   // Counter and accumulate logic for the current request.
   always_comb begin
      pos_ext   = CHANS_W'(position_ff);
      frame_cur = (FRM_W+1)'(frame_ff);
      pos_cur   = position_ff;
      // A position at or beyond the channel count is taken as the wrap to frame+1.
      if (pos_ext >= chans) begin
         pos_cur   = '0;
         frame_cur = frame_cur + 1'b1;
         if (frame_cur > LAST_FRAME) begin
            frame_cur = '0;
         end
      end
      if (frame_cur == '0) begin
         sum_new = sample_ext;
      end else begin
         sum_new = sums_ff[pos_cur] + sample_ext;
      end
      last_frame = (frame_cur == LAST_FRAME);
      sum_mag    = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
      pos_next   = CHANS_W'(pos_cur) + 1'b1;
      frame_next = frame_cur;
      if (pos_next >= chans) begin
         pos_next   = '0;
         frame_next = frame_cur + 1'b1;
         if (frame_next > LAST_FRAME) begin
            frame_next = '0;
         end
      end
   end

   always_comb begin
      sample_bytes_in  = sample_bytes_ff;
      channel_count_in = channel_count_ff;
      position_in      = position_ff;
      frame_in         = frame_ff;
      if (accept) begin
         position_in = POS_W'(pos_next);
         frame_in    = FRM_W'(frame_next);
      end
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLE_BYTES: begin
               sample_bytes_in = csr_data[BYTES_W-1:0];
               position_in     = '0;
               frame_in        = '0;
            end
            CSR_CHANNEL_COUNT: begin
               channel_count_in = csr_data[COUNT_W-1:0];
               position_in      = '0;
               frame_in         = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Division by the block length as a multiply by its rounded-up reciprocal,
   // exact for every sum magnitude of SUM_W bits.
   assign product  = (PROD_W'(s2_hi_ff) << HALF_W) + PROD_W'(s2_lo_ff);
   assign quotient = SUM_W'(product >> DIV_K);
   assign average  = s2_neg_ff ? SUM_W'(-quotient) : quotient;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s2_valid_in  = s2_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s3_move) begin
         rsp_valid_in = s2_valid_ff;
      end
      if (s2_move) begin
         s2_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         s1_valid_in = accept && last_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_bytes_ff  <= RST_SAMPLE_BYTES;
         channel_count_ff <= RST_CHANNEL_COUNT;
         position_ff      <= '0;
         frame_ff         <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         sample_bytes_ff  <= sample_bytes_in;
         channel_count_ff <= channel_count_in;
         position_ff      <= position_in;
         frame_ff         <= frame_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sums_ff[pos_cur] <= sum_new;
      end
      if (s1_move) begin
         s1_neg_ff  <= sum_new[SUM_W-1];
         s1_mag_ff  <= sum_mag;
         s1_chan_ff <= CHAN_IDX_W'(pos_cur);
      end
      if (s2_move) begin
         s2_neg_ff  <= s1_neg_ff;
         s2_hi_ff   <= PP_W'(s1_mag_ff[SUM_W-1:HALF_W]) * PP_W'(MAGIC);
         s2_lo_ff   <= PP_W'(s1_mag_ff[HALF_W-1:0]) * PP_W'(MAGIC);
         s2_chan_ff <= s1_chan_ff;
      end
      if (s3_move) begin
         rsp_average_ff <= average[SAMPLE_W-1:0] & width_mask;
         rsp_chan_ff    <= s2_chan_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_average_raw   = rsp_average_ff;
   assign rsp_channel_index = rsp_chan_ff;

endmodule
